### hdl/ath_pkg.sv
// Shared types, constants and codes for the allocation tracking hash table.
package ath_pkg;

   localparam int TABLE_DEPTH_DEF = 4096;
   localparam int FILL_LIMIT_DEF  = 3584;
   localparam int OWNER_COUNT_DEF = 64;

   localparam int ADDR_W    = 64;
   localparam int SIZE_W    = 32;
   localparam int OWNER_W   = 6;
   localparam int STAT_W    = 64;
   localparam int ENTRIES_W = 12;
   localparam int HOME_W    = 20;

   localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_LOST      = 3'd2,
      ST_FREED     = 3'd3,
      ST_UNTRACKED = 3'd4,
      ST_NULL      = 3'd5
   } status_type;

   typedef struct packed {
      logic                is_free;
      logic [ADDR_W-1:0]   addr;
      logic [SIZE_W-1:0]   size;
      logic [OWNER_W-1:0]  owner;
      logic [HOME_W-1:0]   home;
   } item_type;

   typedef struct packed {
      logic [STAT_W-1:0] live;
      logic [STAT_W-1:0] peak;
      logic [STAT_W-1:0] count;
   } owner_rec_type;

endpackage

### hdl/ath_queue.sv
// Two-entry queue of classified transactions between front and back.
module ath_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_push,
   input  logic              q_pop,
   input  ath_pkg::item_type q_wdata,
   output ath_pkg::item_type q_rdata,
   output logic              q_full,
   output logic              q_empty
);

   ath_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign q_full  = (count_ff == 2'd2);
   assign q_empty = (count_ff == 2'd0);
   assign q_rdata = entry_ff[rd_ptr_ff];
   assign do_push = q_push & ~q_full;
   assign do_pop  = q_pop & ~q_empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_wdata;
      end
   end

endmodule

### hdl/ath_front.sv
// Front end: accepts requests, computes the home slot hash, queues the transaction.
module ath_front #(
   parameter int TABLE_DEPTH = ath_pkg::TABLE_DEPTH_DEF,
   parameter int OWNER_COUNT = ath_pkg::OWNER_COUNT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic                         req_type,
   input  logic [ath_pkg::ADDR_W-1:0]   req_block_address,
   input  logic [ath_pkg::SIZE_W-1:0]   req_block_size,
   input  logic [ath_pkg::OWNER_W-1:0]  req_owner_index,
   input  logic                         clearing,
   input  logic                         q_full,
   output logic                         q_push,
   output ath_pkg::item_type            q_item
);

   localparam logic [ath_pkg::OWNER_W:0]  OWN_LIM   = (ath_pkg::OWNER_W+1)'(OWNER_COUNT);
   localparam logic [ath_pkg::HOME_W-1:0] HOME_MASK = ath_pkg::HOME_W'(TABLE_DEPTH - 1);

   typedef enum logic [4:0] {
      FS_IDLE = 5'b00001,
      FS_MUL0 = 5'b00010,
      FS_MUL1 = 5'b00100,
      FS_MUL2 = 5'b01000,
      FS_PUSH = 5'b10000
   } fstate_type;

   fstate_type        state_ff, state_in;
   ath_pkg::item_type item_ff, item_in;
   logic [31:0]       acc_ff, acc_in;
   logic [31:0]       mul_a, mul_b;
   logic [63:0]       prod;
   logic              accept;

   assign full   = (state_ff != FS_IDLE) | clearing;
   assign accept = push & ~full;
   assign prod   = mul_a * mul_b;

   always_comb begin
      q_item      = item_ff;
      q_item.home = acc_ff[ath_pkg::HOME_W-1:0] & HOME_MASK;
   end

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      acc_in   = acc_ff;
      q_push   = 1'b0;
      mul_a    = item_ff.addr[35:4];
      mul_b    = ath_pkg::GOLDEN[31:0];
      unique case (state_ff)
         FS_IDLE: begin
            if (accept) begin
               item_in.is_free = req_type;
               item_in.addr    = req_block_address;
               item_in.size    = req_block_size;
               item_in.owner   = ({1'b0, req_owner_index} >= OWN_LIM) ? '0 : req_owner_index;
               item_in.home    = '0;
               state_in        = FS_MUL0;
            end
         end
         FS_MUL0: begin
            acc_in   = prod[63:32];
            state_in = FS_MUL1;
         end
         FS_MUL1: begin
            mul_b    = ath_pkg::GOLDEN[63:32];
            acc_in   = acc_ff + prod[31:0];
            state_in = FS_MUL2;
         end
         FS_MUL2: begin
            mul_a    = {4'b0, item_ff.addr[63:36]};
            acc_in   = acc_ff + prod[31:0];
            state_in = FS_PUSH;
         end
         FS_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      acc_ff  <= acc_in;
   end

endmodule

### hdl/ath_back.sv
// Back end: probes the slot table, inserts and deletes entries, keeps statistics.
module ath_back #(
   parameter int TABLE_DEPTH = ath_pkg::TABLE_DEPTH_DEF,
   parameter int FILL_LIMIT  = ath_pkg::FILL_LIMIT_DEF,
   parameter int OWNER_COUNT = ath_pkg::OWNER_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   output logic                           clearing,
   input  logic                           q_empty,
   output logic                           q_pop,
   input  ath_pkg::item_type              q_item,
   output logic                           empty,
   input  logic                           pop,
   output logic [2:0]                     rsp_status,
   output logic [ath_pkg::OWNER_W-1:0]    rsp_affected_owner,
   output logic [ath_pkg::SIZE_W-1:0]     rsp_freed_size,
   output logic [ath_pkg::STAT_W-1:0]     rsp_total_live,
   output logic [ath_pkg::STAT_W-1:0]     rsp_total_peak,
   output logic [ath_pkg::ENTRIES_W-1:0]  rsp_entries_tracked,
   output logic [ath_pkg::STAT_W-1:0]     rsp_lost_inserts,
   output logic [ath_pkg::STAT_W-1:0]     rsp_unknown_frees,
   output logic [ath_pkg::STAT_W-1:0]     rsp_owner_live,
   output logic [ath_pkg::STAT_W-1:0]     rsp_owner_peak,
   output logic [ath_pkg::STAT_W-1:0]     rsp_owner_allocs
);

   localparam int IDXW = $clog2(TABLE_DEPTH);
   localparam int CNTW = $clog2(TABLE_DEPTH + 1);
   localparam int OW   = (OWNER_COUNT > 1) ? $clog2(OWNER_COUNT) : 1;
   localparam int LIMW = $clog2(FILL_LIMIT + 1) + CNTW;
   localparam logic [IDXW-1:0]   LAST_IDX = IDXW'(TABLE_DEPTH - 1);
   localparam logic [IDXW:0]     LAST_N   = (IDXW+1)'(TABLE_DEPTH - 1);
   localparam logic [LIMW-1:0]   FILL_LIM = LIMW'(FILL_LIMIT);
   localparam logic [ath_pkg::OWNER_W:0] OWN_LIM = (ath_pkg::OWNER_W+1)'(OWNER_COUNT);

   typedef struct packed {
      logic [ath_pkg::ADDR_W-1:0]  addr;
      logic [ath_pkg::SIZE_W-1:0]  size;
      logic [ath_pkg::OWNER_W:0]   opo;
      logic [IDXW-1:0]             home;
   } slot_type;

   typedef enum logic [6:0] {
      BS_CLEAR  = 7'b0000001,
      BS_IDLE   = 7'b0000010,
      BS_PROBE  = 7'b0000100,
      BS_SHIFT  = 7'b0001000,
      BS_OWNRD  = 7'b0010000,
      BS_OWNUPD = 7'b0100000,
      BS_FIN    = 7'b1000000
   } bstate_type;

   slot_type              slot_mem [TABLE_DEPTH];
   ath_pkg::owner_rec_type own_mem [OWNER_COUNT];

   bstate_type            state_ff, state_in;
   logic [IDXW-1:0]       clr_ff, clr_in;
   ath_pkg::item_type     item_ff, item_in;
   logic [IDXW-1:0]       idx_ff, idx_in;
   logic [IDXW-1:0]       gap_ff, gap_in;
   logic [IDXW:0]         n_ff, n_in;
   ath_pkg::status_type   status_ff, status_in;
   logic [ath_pkg::OWNER_W-1:0] aff_ff, aff_in;
   logic [ath_pkg::SIZE_W-1:0]  fsize_ff, fsize_in;
   logic [ath_pkg::STAT_W-1:0]  live_ff, live_in;
   logic [ath_pkg::STAT_W-1:0]  peak_ff, peak_in;
   logic [CNTW-1:0]             tracked_ff, tracked_in;
   logic [ath_pkg::STAT_W-1:0]  lost_ff, lost_in;
   logic [ath_pkg::STAT_W-1:0]  untr_ff, untr_in;
   logic [OWNER_COUNT-1:0]      own_valid_ff, own_valid_in;
   slot_type                    rslot_ff;
   ath_pkg::owner_rec_type      own_rd_ff;

   logic                        out_valid_ff, out_valid_in;
   ath_pkg::status_type         out_status_ff, out_status_in;
   logic [ath_pkg::OWNER_W-1:0] out_aff_ff, out_aff_in;
   logic [ath_pkg::SIZE_W-1:0]  out_fsize_ff, out_fsize_in;
   logic [ath_pkg::STAT_W-1:0]  out_live_ff, out_live_in;
   logic [ath_pkg::STAT_W-1:0]  out_peak_ff, out_peak_in;
   logic [CNTW-1:0]             out_tracked_ff, out_tracked_in;
   logic [ath_pkg::STAT_W-1:0]  out_lost_ff, out_lost_in;
   logic [ath_pkg::STAT_W-1:0]  out_untr_ff, out_untr_in;
   ath_pkg::owner_rec_type      out_own_ff, out_own_in;

   logic                        slot_we;
   logic [IDXW-1:0]             slot_wa, slot_ra;
   slot_type                    slot_wd;
   logic                        own_we;
   logic [OW-1:0]               own_ra;
   ath_pkg::owner_rec_type      own_wd, own_cur;

   logic [IDXW-1:0]             idx_nx, dh, dp;
   logic                        hit, vacant;
   logic [ath_pkg::OWNER_W-1:0] slot_own;
   logic [ath_pkg::STAT_W-1:0]  live_calc, olive_calc;
   logic [CNTW+ath_pkg::ENTRIES_W-1:0] tracked_ext;

   assign clearing = (state_ff == BS_CLEAR);
   assign empty    = ~out_valid_ff;
   assign idx_nx   = idx_ff + 1'b1;
   assign hit      = (rslot_ff.addr == item_ff.addr);
   assign vacant   = (rslot_ff.opo == '0);
   assign dh       = rslot_ff.home - gap_ff;
   assign dp       = idx_ff - gap_ff;
   assign slot_own = ((rslot_ff.opo - 1'b1) >= OWN_LIM) ? '0 :
                     ath_pkg::OWNER_W'(rslot_ff.opo - 1'b1);
   assign own_cur  = own_valid_ff[aff_ff[OW-1:0]] ? own_rd_ff : '0;

   assign tracked_ext         = {{ath_pkg::ENTRIES_W{1'b0}}, out_tracked_ff};
   assign rsp_status          = out_status_ff;
   assign rsp_affected_owner  = out_aff_ff;
   assign rsp_freed_size      = out_fsize_ff;
   assign rsp_total_live      = out_live_ff;
   assign rsp_total_peak      = out_peak_ff;
   assign rsp_entries_tracked = tracked_ext[ath_pkg::ENTRIES_W-1:0];
   assign rsp_lost_inserts    = out_lost_ff;
   assign rsp_unknown_frees   = out_untr_ff;
   assign rsp_owner_live      = out_own_ff.live;
   assign rsp_owner_peak      = out_own_ff.peak;
   assign rsp_owner_allocs    = out_own_ff.count;

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      item_in        = item_ff;
      idx_in         = idx_ff;
      gap_in         = gap_ff;
      n_in           = n_ff;
      status_in      = status_ff;
      aff_in         = aff_ff;
      fsize_in       = fsize_ff;
      live_in        = live_ff;
      peak_in        = peak_ff;
      tracked_in     = tracked_ff;
      lost_in        = lost_ff;
      untr_in        = untr_ff;
      own_valid_in   = own_valid_ff;
      out_valid_in   = out_valid_ff & ~pop;
      out_status_in  = out_status_ff;
      out_aff_in     = out_aff_ff;
      out_fsize_in   = out_fsize_ff;
      out_live_in    = out_live_ff;
      out_peak_in    = out_peak_ff;
      out_tracked_in = out_tracked_ff;
      out_lost_in    = out_lost_ff;
      out_untr_in    = out_untr_ff;
      out_own_in     = out_own_ff;
      q_pop          = 1'b0;
      slot_we        = 1'b0;
      slot_wa        = gap_ff;
      slot_wd        = rslot_ff;
      slot_ra        = idx_nx;
      own_we         = 1'b0;
      own_ra         = aff_ff[OW-1:0];
      own_wd         = own_cur;
      live_calc      = live_ff;
      olive_calc     = own_cur.live;
      unique case (state_ff)
         BS_CLEAR: begin
            slot_we = 1'b1;
            slot_wa = clr_ff;
            slot_wd = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = BS_IDLE;
            end
         end
         BS_IDLE: begin
            slot_ra = q_item.home[IDXW-1:0];
            if (!q_empty && !out_valid_ff) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               aff_in   = '0;
               fsize_in = '0;
               idx_in   = q_item.home[IDXW-1:0];
               n_in     = '0;
               if (q_item.addr == '0) begin
                  status_in = ath_pkg::ST_NULL;
                  state_in  = BS_FIN;
               end else if (q_item.is_free == ath_pkg::REQ_ALLOC &&
                            LIMW'(tracked_ff) >= FILL_LIM) begin
                  status_in = ath_pkg::ST_LOST;
                  state_in  = BS_FIN;
               end else begin
                  state_in = BS_PROBE;
               end
            end
         end
         BS_PROBE: begin
            idx_in = idx_nx;
            n_in   = n_ff + 1'b1;
            if (item_ff.is_free == ath_pkg::REQ_ALLOC) begin
               if (vacant) begin
                  slot_we      = 1'b1;
                  slot_wa      = idx_ff;
                  slot_wd.addr = item_ff.addr;
                  slot_wd.size = item_ff.size;
                  slot_wd.opo  = {1'b0, item_ff.owner} + 1'b1;
                  slot_wd.home = item_ff.home[IDXW-1:0];
                  status_in    = ath_pkg::ST_INSERTED;
                  aff_in       = item_ff.owner;
                  state_in     = BS_OWNRD;
               end else if (hit) begin
                  status_in = ath_pkg::ST_DUPLICATE;
                  state_in  = BS_FIN;
               end else if (n_ff == LAST_N) begin
                  status_in = ath_pkg::ST_LOST;
                  state_in  = BS_FIN;
               end
            end else begin
               if (vacant) begin
                  status_in = ath_pkg::ST_UNTRACKED;
                  state_in  = BS_FIN;
               end else if (hit) begin
                  status_in = ath_pkg::ST_FREED;
                  aff_in    = slot_own;
                  fsize_in  = rslot_ff.size;
                  gap_in    = idx_ff;
                  state_in  = BS_SHIFT;
               end else if (n_ff == LAST_N) begin
                  status_in = ath_pkg::ST_UNTRACKED;
                  state_in  = BS_FIN;
               end
            end
         end
         BS_SHIFT: begin
            idx_in = idx_nx;
            if (vacant || idx_ff == gap_ff) begin
               slot_we  = 1'b1;
               slot_wd  = '0;
               state_in = BS_OWNRD;
            end else if (dh == '0 || dh > dp) begin
               slot_we = 1'b1;
               gap_in  = idx_ff;
            end
         end
         BS_OWNRD: begin
            state_in = BS_OWNUPD;
         end
         BS_OWNUPD: begin
            if (status_ff == ath_pkg::ST_INSERTED) begin
               live_calc    = live_ff + 64'(item_ff.size);
               olive_calc   = own_cur.live + 64'(item_ff.size);
               tracked_in   = tracked_ff + 1'b1;
               own_wd.count = own_cur.count + 1'b1;
               if (live_calc > peak_ff) begin
                  peak_in = live_calc;
               end
               if (olive_calc > own_cur.peak) begin
                  own_wd.peak = olive_calc;
               end
            end else begin
               live_calc  = live_ff - 64'(fsize_ff);
               olive_calc = own_cur.live - 64'(fsize_ff);
               tracked_in = tracked_ff - 1'b1;
            end
            own_wd.live    = olive_calc;
            own_we         = 1'b1;
            own_valid_in[aff_ff[OW-1:0]] = 1'b1;
            live_in        = live_calc;
            out_valid_in   = 1'b1;
            out_status_in  = status_ff;
            out_aff_in     = aff_ff;
            out_fsize_in   = fsize_ff;
            out_live_in    = live_calc;
            out_peak_in    = peak_in;
            out_tracked_in = tracked_in;
            out_lost_in    = lost_ff;
            out_untr_in    = untr_ff;
            out_own_in     = own_wd;
            state_in       = BS_IDLE;
         end
         BS_FIN: begin
            if (status_ff == ath_pkg::ST_LOST) begin
               lost_in = lost_ff + 1'b1;
            end
            if (status_ff == ath_pkg::ST_UNTRACKED) begin
               untr_in = untr_ff + 1'b1;
            end
            out_valid_in   = 1'b1;
            out_status_in  = status_ff;
            out_aff_in     = '0;
            out_fsize_in   = '0;
            out_live_in    = live_ff;
            out_peak_in    = peak_ff;
            out_tracked_in = tracked_ff;
            out_lost_in    = lost_in;
            out_untr_in    = untr_in;
            out_own_in     = '0;
            state_in       = BS_IDLE;
         end
         default: state_in = BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_CLEAR;
         clr_ff       <= '0;
         live_ff      <= '0;
         peak_ff      <= '0;
         tracked_ff   <= '0;
         lost_ff      <= '0;
         untr_ff      <= '0;
         own_valid_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         live_ff      <= live_in;
         peak_ff      <= peak_in;
         tracked_ff   <= tracked_in;
         lost_ff      <= lost_in;
         untr_ff      <= untr_in;
         own_valid_ff <= own_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      idx_ff         <= idx_in;
      gap_ff         <= gap_in;
      n_ff           <= n_in;
      status_ff      <= status_in;
      aff_ff         <= aff_in;
      fsize_ff       <= fsize_in;
      out_status_ff  <= out_status_in;
      out_aff_ff     <= out_aff_in;
      out_fsize_ff   <= out_fsize_in;
      out_live_ff    <= out_live_in;
      out_peak_ff    <= out_peak_in;
      out_tracked_ff <= out_tracked_in;
      out_lost_ff    <= out_lost_in;
      out_untr_ff    <= out_untr_in;
      out_own_ff     <= out_own_in;
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      rslot_ff <= slot_mem[slot_ra];
   end

   always_ff @(posedge clock) begin
      if (own_we) begin
         own_mem[aff_ff[OW-1:0]] <= own_wd;
      end
      own_rd_ff <= own_mem[own_ra];
   end

endmodule

### hdl/allocation_tracking_hash_table.sv
// Top level of the allocation tracking hash table.
// The front hashes in its MUL0, MUL1 and MUL2 states, then queues the item. The back probes
// slots one per cycle (lookup plus backward-shift walk), then updates an owner record on
// insert or free. The back takes the next item only after the last response is popped.
// Reset: synchronous; afterwards a clearing pass over all TABLE_DEPTH slots holds full high.
// Statistics and owner records read as zero after reset.
module allocation_tracking_hash_table #(
   parameter int TABLE_DEPTH = ath_pkg::TABLE_DEPTH_DEF,
   parameter int FILL_LIMIT  = ath_pkg::FILL_LIMIT_DEF,
   parameter int OWNER_COUNT = ath_pkg::OWNER_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic                           req_type,
   input  logic [ath_pkg::ADDR_W-1:0]     req_block_address,
   input  logic [ath_pkg::SIZE_W-1:0]     req_block_size,
   input  logic [ath_pkg::OWNER_W-1:0]    req_owner_index,
   output logic                           empty,
   input  logic                           pop,
   output logic [2:0]                     rsp_status,
   output logic [ath_pkg::OWNER_W-1:0]    rsp_affected_owner,
   output logic [ath_pkg::SIZE_W-1:0]     rsp_freed_size,
   output logic [ath_pkg::STAT_W-1:0]     rsp_total_live,
   output logic [ath_pkg::STAT_W-1:0]     rsp_total_peak,
   output logic [ath_pkg::ENTRIES_W-1:0]  rsp_entries_tracked,
   output logic [ath_pkg::STAT_W-1:0]     rsp_lost_inserts,
   output logic [ath_pkg::STAT_W-1:0]     rsp_unknown_frees,
   output logic [ath_pkg::STAT_W-1:0]     rsp_owner_live,
   output logic [ath_pkg::STAT_W-1:0]     rsp_owner_peak,
   output logic [ath_pkg::STAT_W-1:0]     rsp_owner_allocs
);

   logic              clearing;
   logic              q_push, q_pop, q_full, q_empty;
   ath_pkg::item_type q_wdata, q_rdata;

   ath_front #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .OWNER_COUNT (OWNER_COUNT)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_type          (req_type),
      .req_block_address (req_block_address),
      .req_block_size    (req_block_size),
      .req_owner_index   (req_owner_index),
      .clearing          (clearing),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_item            (q_wdata)
   );

   ath_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_pop   (q_pop),
      .q_wdata (q_wdata),
      .q_rdata (q_rdata),
      .q_full  (q_full),
      .q_empty (q_empty)
   );

   ath_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .FILL_LIMIT  (FILL_LIMIT),
      .OWNER_COUNT (OWNER_COUNT)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .clearing            (clearing),
      .q_empty             (q_empty),
      .q_pop               (q_pop),
      .q_item              (q_rdata),
      .empty               (empty),
      .pop                 (pop),
      .rsp_status          (rsp_status),
      .rsp_affected_owner  (rsp_affected_owner),
      .rsp_freed_size      (rsp_freed_size),
      .rsp_total_live      (rsp_total_live),
      .rsp_total_peak      (rsp_total_peak),
      .rsp_entries_tracked (rsp_entries_tracked),
      .rsp_lost_inserts    (rsp_lost_inserts),
      .rsp_unknown_frees   (rsp_unknown_frees),
      .rsp_owner_live      (rsp_owner_live),
      .rsp_owner_peak      (rsp_owner_peak),
      .rsp_owner_allocs    (rsp_owner_allocs)
   );

endmodule

### hdl/ath_checker.sv
// Port-level checker for the allocation tracking hash table, with its bind.
module ath_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           full,
   input logic                           empty,
   input logic                           pop,
   input logic [2:0]                     rsp_status,
   input logic [ath_pkg::OWNER_W-1:0]    rsp_affected_owner,
   input logic [ath_pkg::SIZE_W-1:0]     rsp_freed_size,
   input logic [ath_pkg::STAT_W-1:0]     rsp_owner_live,
   input logic [ath_pkg::STAT_W-1:0]     rsp_owner_allocs
);

   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> (full && empty))
      else $error("block not clearing after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_status)))
      else $error("pending transaction changed before pop");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_status <= 3'(ath_pkg::ST_NULL)))
      else $error("status code out of range");

   a_idle_owner_fields: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status != 3'(ath_pkg::ST_INSERTED) &&
       rsp_status != 3'(ath_pkg::ST_FREED)) |->
      (rsp_affected_owner == '0 && rsp_freed_size == '0 &&
       rsp_owner_live == '0 && rsp_owner_allocs == '0))
      else $error("owner fields set for untouched transaction");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status == 3'(ath_pkg::ST_INSERTED)) |-> (rsp_owner_allocs != '0))
      else $error("insert without owner allocation count");

endmodule

bind allocation_tracking_hash_table ath_checker u_ath_checker (
   .clock              (clock),
   .reset              (reset),
   .full               (full),
   .empty              (empty),
   .pop                (pop),
   .rsp_status         (rsp_status),
   .rsp_affected_owner (rsp_affected_owner),
   .rsp_freed_size     (rsp_freed_size),
   .rsp_owner_live     (rsp_owner_live),
   .rsp_owner_allocs   (rsp_owner_allocs)
);
